@@ src/cis_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cis_pkg: shared types and constants for the CPU instruction subset core
// Transaction structs, opcodes, flag masks, reset values and ALU port types.
// ----------------------------------------------------------------------------
package cis_pkg;

   // Memory geometry; the depth must be a power of two (address wraps)
   localparam int MEM_DEPTH = 65536;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   // Reset values of the architectural registers
   localparam logic [15:0] PC_RESET = 16'h0100;
   localparam logic [15:0] AF_RESET = 16'h01B0;
   localparam logic [15:0] BC_RESET = 16'h0013;
   localparam logic [15:0] DE_RESET = 16'h00D8;
   localparam logic [15:0] HL_RESET = 16'h014D;

   // Flag register bits
   localparam logic [7:0] FLAG_Z = 8'h80;
   localparam logic [7:0] FLAG_N = 8'h40;
   localparam logic [7:0] FLAG_H = 8'h20;
   localparam logic [7:0] FLAG_C = 8'h10;

   // Supported opcodes; anything else executes as NOP
   localparam logic [7:0] OP_NOP       = 8'h00;
   localparam logic [7:0] OP_JP_NN     = 8'hC3;
   localparam logic [7:0] OP_LD_C_B    = 8'h48;
   localparam logic [7:0] OP_LD_C_D    = 8'h4A;
   localparam logic [7:0] OP_CPL       = 8'h2F;
   localparam logic [7:0] OP_DEC_BC    = 8'h0B;
   localparam logic [7:0] OP_DEC_H     = 8'h25;
   localparam logic [7:0] OP_DEC_E     = 8'h1D;
   localparam logic [7:0] OP_LD_HLI_A  = 8'h22;
   localparam logic [7:0] OP_ADD_HL_DE = 8'h19;
   localparam logic [7:0] OP_LD_C_D8   = 8'h0E;

   // Request action codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   typedef struct packed {
      logic        action;
      logic [15:0] load_address;
      logic [7:0]  load_data;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] program_counter;
      logic [7:0]  executed_opcode;
      logic [7:0]  accumulator;
      logic [7:0]  flag_bits;
      logic [15:0] pair_bc;
      logic [15:0] pair_de;
      logic [15:0] pair_hl;
   } rsp_payload_type;

   // Shared adder port
   typedef struct packed {
      logic [15:0] a;
      logic [15:0] b;
      logic        cin;
   } alu_in_type;

   typedef struct packed {
      logic [15:0] sum;
      logic        half;   // carry out of bit 11
      logic        carry;  // carry out of bit 15
   } alu_out_type;

   // Sequencer states
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_FETCH  = 7'b0000010,
      S_DECODE = 7'b0000100,
      S_IMM_LO = 7'b0001000,
      S_IMM_HI = 7'b0010000,
      S_EXEC   = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   // Flags after an 8-bit decrement: Z, N=1, H on borrow from the low nibble
   function automatic logic [7:0] dec_flags(input logic [7:0] f,
                                            input logic [7:0] old_val,
                                            input logic [7:0] new_val);
      logic [7:0] res;
      begin
         res = (f & ~(FLAG_Z | FLAG_H)) | FLAG_N;
         if (old_val[3:0] == 4'h0) res = res | FLAG_H;
         if (new_val == 8'h00) res = res | FLAG_Z;
         return res;
      end
   endfunction

endpackage

@@ src/cpu_instruction_subset_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_instruction_subset_step: small SM83-subset CPU core with byte memory
// A load transaction writes one memory byte; a step transaction fetches and
// executes one instruction. Every request returns one register snapshot.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake            Payload
//   req_      in          req_valid/req_ready  req_payload_type
//   rsp_      out         rsp_valid/rsp_ready  rsp_payload_type
//
// A load goes from idle straight to the result state; a step walks fetch,
// decode, then execute or the immediate states of LD C,d8 and JP nn, one memory
// read per state; the core is idle again in the same cycle the result is raised.
// Reset puts the registers to their power-on values; memory is not cleared
// and must be loaded before it is fetched.
// A held result stalls the core in its final state; req_ready is high only
// while the core is idle.
// ----------------------------------------------------------------------------
module cpu_instruction_subset_step
   import cis_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   state_type       state_ff, state_in;
   logic [15:0]     pc_ff, pc_in;
   logic [7:0]      a_ff, a_in;
   logic [7:0]      f_ff, f_in;
   logic [15:0]     bc_ff, bc_in;
   logic [15:0]     de_ff, de_in;
   logic [15:0]     hl_ff, hl_in;
   logic [7:0]      opcode_ff, opcode_in;
   logic [7:0]      imm_lo_ff, imm_lo_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic              ram_we;
   logic [MEM_AW-1:0] ram_addr;
   logic [7:0]        ram_wdata;
   logic [7:0]        ram_rdata;
   alu_in_type        alu_in;
   alu_out_type       alu_out;

   cis_ram #(
      .WIDTH(8),
      .DEPTH(MEM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   cis_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      a_in         = a_ff;
      f_in         = f_ff;
      bc_in        = bc_ff;
      de_in        = de_ff;
      hl_in        = hl_ff;
      opcode_in    = opcode_ff;
      imm_lo_in    = imm_lo_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_addr     = pc_ff[MEM_AW-1:0];
      ram_wdata    = a_ff;
      // adder defaults to PC + 1
      alu_in.a     = pc_ff;
      alu_in.b     = 16'h0000;
      alu_in.cin   = 1'b1;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.action == ACT_LOAD) begin
                  ram_we    = 1'b1;
                  ram_addr  = req_data.load_address[MEM_AW-1:0];
                  ram_wdata = req_data.load_data;
                  opcode_in = OP_NOP;
                  state_in  = S_DONE;
               end else begin
                  state_in  = S_FETCH;
               end
            end
         end
         // opcode read at PC
         S_FETCH: begin
            pc_in    = alu_out.sum;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            opcode_in = ram_rdata;
            if (ram_rdata == OP_JP_NN || ram_rdata == OP_LD_C_D8) begin
               pc_in    = alu_out.sum;
               state_in = S_IMM_LO;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_IMM_LO: begin
            imm_lo_in = ram_rdata;
            if (opcode_ff == OP_JP_NN) begin
               pc_in    = alu_out.sum;
               state_in = S_IMM_HI;
            end else begin
               bc_in    = {bc_ff[15:8], ram_rdata};
               state_in = S_DONE;
            end
         end
         // jump target is little-endian
         S_IMM_HI: begin
            pc_in    = {ram_rdata, imm_lo_ff};
            state_in = S_DONE;
         end
         S_EXEC: begin
            case (opcode_ff)
               OP_LD_C_B: begin
                  bc_in = {bc_ff[15:8], bc_ff[15:8]};
               end
               OP_LD_C_D: begin
                  bc_in = {bc_ff[15:8], de_ff[15:8]};
               end
               OP_CPL: begin
                  a_in = ~a_ff;
                  f_in = f_ff | FLAG_N | FLAG_H;
               end
               OP_DEC_BC: begin
                  alu_in.a   = bc_ff;
                  alu_in.b   = 16'hFFFF;
                  alu_in.cin = 1'b0;
                  bc_in      = alu_out.sum;
               end
               OP_DEC_H: begin
                  alu_in.a   = {8'h00, hl_ff[15:8]};
                  alu_in.b   = 16'hFFFF;
                  alu_in.cin = 1'b0;
                  hl_in      = {alu_out.sum[7:0], hl_ff[7:0]};
                  f_in       = dec_flags(f_ff, hl_ff[15:8], alu_out.sum[7:0]);
               end
               OP_DEC_E: begin
                  alu_in.a   = {8'h00, de_ff[7:0]};
                  alu_in.b   = 16'hFFFF;
                  alu_in.cin = 1'b0;
                  de_in      = {de_ff[15:8], alu_out.sum[7:0]};
                  f_in       = dec_flags(f_ff, de_ff[7:0], alu_out.sum[7:0]);
               end
               OP_LD_HLI_A: begin
                  ram_we     = 1'b1;
                  ram_addr   = hl_ff[MEM_AW-1:0];
                  ram_wdata  = a_ff;
                  alu_in.a   = hl_ff;
                  hl_in      = alu_out.sum;
               end
               OP_ADD_HL_DE: begin
                  alu_in.a   = hl_ff;
                  alu_in.b   = de_ff;
                  alu_in.cin = 1'b0;
                  hl_in      = alu_out.sum;
                  f_in       = (f_ff & ~(FLAG_N | FLAG_H | FLAG_C))
                             | (alu_out.half  ? FLAG_H : 8'h00)
                             | (alu_out.carry ? FLAG_C : 8'h00);
               end
               default: begin
               end
            endcase
            state_in = S_DONE;
         end
         // wait for the output register to free up
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.program_counter = pc_ff;
               rsp_in.executed_opcode = opcode_ff;
               rsp_in.accumulator     = a_ff;
               rsp_in.flag_bits       = f_ff;
               rsp_in.pair_bc         = bc_ff;
               rsp_in.pair_de         = de_ff;
               rsp_in.pair_hl         = hl_ff;
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= PC_RESET;
         a_ff         <= AF_RESET[15:8];
         f_ff         <= AF_RESET[7:0];
         bc_ff        <= BC_RESET;
         de_ff        <= DE_RESET;
         hl_ff        <= HL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         a_ff         <= a_in;
         f_ff         <= f_in;
         bc_ff        <= bc_in;
         de_ff        <= de_in;
         hl_ff        <= hl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      opcode_ff <= opcode_in;
      imm_lo_ff <= imm_lo_in;
      rsp_ff    <= rsp_in;
   end

   // A load transaction goes straight to the result state
   a_load_to_done: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.action == ACT_LOAD) |=> (state_ff == S_DONE))
      else $error("load did not go to result state");

   // Memory is written only by a load or by LD (HL+),A
   a_ram_write_src: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == S_IDLE && req_data.action == ACT_LOAD)
                  || (state_ff == S_EXEC && opcode_ff == OP_LD_HLI_A)))
      else $error("unexpected memory write");

   // Jump loads the little-endian target
   a_jump_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IMM_HI) |=> (pc_ff == {$past(ram_rdata), $past(imm_lo_ff)}))
      else $error("jump target mismatch");

   // A new result appears only from the result state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_DONE))
      else $error("result raised outside result state");

   // The low nibble of F never changes
   a_flag_low_nibble: assert property (@(posedge clock) disable iff (reset)
      $stable(f_ff[3:0]))
      else $error("low flag nibble changed");

endmodule

@@ src/cis_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cis_ram: generic single-port RAM
// One read or write port, read data registered, no reset on contents.
// ----------------------------------------------------------------------------
module cis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/cis_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cis_alu: shared 16-bit adder
// Serves PC/HL increment, 8- and 16-bit decrement and ADD HL,DE.
// ----------------------------------------------------------------------------
module cis_alu
   import cis_pkg::*;
(
   input  alu_in_type  alu_in,
   output alu_out_type alu_out
);

   logic [12:0] low_sum;
   logic [4:0]  high_sum;

   // Split at bit 12 so the half carry falls out directly
   assign low_sum  = {1'b0, alu_in.a[11:0]} + {1'b0, alu_in.b[11:0]} + {12'h000, alu_in.cin};
   assign high_sum = {1'b0, alu_in.a[15:12]} + {1'b0, alu_in.b[15:12]} + {4'h0, low_sum[12]};

   assign alu_out.sum   = {high_sum[3:0], low_sum[11:0]};
   assign alu_out.half  = low_sum[12];
   assign alu_out.carry = high_sum[4];

endmodule
